@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion wrappers, clocked on the rising edge with a
// synchronous active-high reset that disables checking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpa_pkg
// shared codes, reset values and the controller command type of the
// per-cpu page allocator
// ----------------------------------------------------------------------------
package pcpa_pkg;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // configuration register indexes
  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_STOP  = 1'b1;

  localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_STOP_RST  = 32'h8800_0000;

  typedef struct packed {
    logic load;    // capture request, launch link read
    logic commit;  // finish request, update lists, load result
  } cmd_t;

endpackage

@@ sv/pcpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcpa_ctrl
// two-state sequencer: take a request, then finish it once the result
// register is free; owns the result valid flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output pcpa_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.load) state_next = S_EXEC;
      S_EXEC: if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_load_enters_exec, clk, rst, cmd.load, state == S_EXEC, "load missed exec")
  `ASSERT_NEXT(a_commit_to_idle, clk, rst, cmd.commit, state == S_IDLE && out_valid, "no word")
  `ASSERT_HOLDS(a_rise_on_commit, clk, rst, $rose(out_valid) |-> $past(cmd.commit), "no commit")

endmodule

@@ sv/pcpa_dp.sv @@
// ----------------------------------------------------------------------------
// pcpa_dp
// allocator datapath: region registers, per-cpu list heads, next-link
// memory, address checks and the result register
// ----------------------------------------------------------------------------
module pcpa_dp #(
  parameter int NUM_CPUS   = 8,
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  pcpa_pkg::cmd_t  cmd,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_kind,
  input  logic [2:0]      in_cpu,
  input  logic [31:0]     in_addr,
  output logic [31:0]     granted_address,
  output logic [1:0]      status
);

  localparam int IW = $clog2(MAX_PAGES);
  localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SH = $clog2(PAGE_BYTES);  // page size is a power of two

  // region registers, base is region_start rounded up to a page
  logic [31:0] region_start;
  logic [31:0] region_stop;
  logic [32:0] base;
  logic [31:0] start_src;
  logic [32:0] start_sum;
  logic [32:0] base_next;

  // list state
  logic [NUM_CPUS-1:0] nonempty;
  logic [IW-1:0]       head [NUM_CPUS];
  logic [IW:0]         link_mem [MAX_PAGES];  // {has successor, successor}
  logic [IW:0]         link_rd;

  // captured request
  logic          op_kind;
  logic [2:0]    op_cpu;
  logic [31:0]   op_addr;
  logic [CW-1:0] op_src;
  logic          op_hit;
  logic [IW-1:0] op_top;

  // source selection at load
  logic [6:0]    cpu_ext;
  logic          own_ok;
  logic [CW-1:0] low_src;
  logic [CW-1:0] src;

  // free checks at commit
  logic [6:0]      op_cpu_ext;
  logic [CW-1:0]   op_cidx;
  logic [32:0]     diff;
  logic [32-SH:0]  pnum;
  logic            free_ok;
  logic            push;
  logic [IW-1:0]   page;
  logic [IW+SH-1:0] offset;
  logic [31:0]     grant;

  assign start_src = rst ? pcpa_pkg::REGION_START_RST : cfg_data;
  assign start_sum = {1'b0, start_src} + 33'(PAGE_BYTES - 1);
  assign base_next = {start_sum[32:SH], {SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= pcpa_pkg::REGION_START_RST;
      region_stop  <= pcpa_pkg::REGION_STOP_RST;
      base         <= base_next;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcpa_pkg::REG_REGION_START: begin
          region_start <= cfg_data;
          base         <= base_next;
        end
        pcpa_pkg::REG_REGION_STOP: region_stop <= cfg_data;
        default: ;
      endcase
    end
  end

  // own list first, otherwise lowest nonempty list
  always_comb begin
    cpu_ext = {4'b0, in_cpu};
    own_ok  = (cpu_ext < 7'(NUM_CPUS)) && nonempty[cpu_ext[CW-1:0]];
    low_src = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (nonempty[i]) low_src = CW'(i);
    end
    src = own_ok ? cpu_ext[CW-1:0] : low_src;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind <= in_kind;
      op_cpu  <= in_cpu;
      op_addr <= in_addr;
      op_src  <= src;
      op_hit  <= |nonempty;
      op_top  <= head[src];
      link_rd <= link_mem[head[src]];
    end
  end

  always_comb begin
    op_cpu_ext = {4'b0, op_cpu};
    op_cidx    = op_cpu_ext[CW-1:0];
    diff       = {1'b0, op_addr} - base;
    pnum       = diff[32:SH];
    page       = pnum[IW-1:0];
    free_ok    = (op_cpu_ext < 7'(NUM_CPUS))
              && (op_addr[SH-1:0] == '0)
              && (op_addr >= region_start)
              && (op_addr < region_stop)
              && (33'(pnum) < 33'(MAX_PAGES));
    push       = (op_kind == pcpa_pkg::KIND_FREE) && free_ok;
    offset     = {op_top, {SH{1'b0}}};
    grant      = base[31:0] + 32'(offset);
  end

  // push writes the old head as the new page's successor
  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      link_mem[page] <= {nonempty[op_cidx], head[op_cidx]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (push) begin
        head[op_cidx] <= page;
      end else if (op_kind == pcpa_pkg::KIND_ALLOC && op_hit && link_rd[IW]) begin
        head[op_src] <= link_rd[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (cmd.commit) begin
      if (push) begin
        nonempty[op_cidx] <= 1'b1;
      end else if (op_kind == pcpa_pkg::KIND_ALLOC && op_hit && !link_rd[IW]) begin
        nonempty[op_src] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      priority if (op_kind == pcpa_pkg::KIND_FREE) begin
        granted_address <= '0;
        status          <= free_ok ? pcpa_pkg::ST_OK : pcpa_pkg::ST_BAD_ADDR;
      end else if (op_hit) begin
        granted_address <= grant;
        status          <= pcpa_pkg::ST_OK;
      end else begin
        granted_address <= '0;
        status          <= pcpa_pkg::ST_NO_MEM;
      end
    end
  end

endmodule

@@ sv/per_cpu_page_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// physical page allocator with one lifo free list per cpu and stealing
// from the lowest-numbered nonempty list when the own list is empty
// ----------------------------------------------------------------------------
// channel   dir  tdata                           tuser
// s_axis    in   [2:0] cpu, [34:3] page_address  [0] kind
// m_axis    out  [31:0] granted_address          [1:0] status
// cfg       in   cfg_index 0 region_start, 1 region_stop, cfg_data 32 bits
//
// one request at a time: the load step reads the chosen list's
// next link from the link memory, the commit step rewrites the head
// result waits in an output register; the next request is taken while it waits
// a request holds in its commit step only while the output register is full
// reset empties every list and loads the region registers; no clearing pass
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator #(
  parameter int NUM_CPUS   = 8,
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cpu, page_address, zero fill
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // granted_address
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  pcpa_pkg::cmd_t cmd;

  pcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  pcpa_dp #(
    .NUM_CPUS   (NUM_CPUS),
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (s_axis_tuser),
    .in_cpu          (s_axis_tdata[2:0]),
    .in_addr         (s_axis_tdata[34:3]),
    .granted_address (m_axis_tdata),
    .status          (m_axis_tuser)
  );

endmodule
